// File: rtl/ptok_pkg.sv
// ----------------------------------------------------------------------------
// ptok_pkg
// shared types, codes and lookup functions of the punctuation tokenizer
// ----------------------------------------------------------------------------
package ptok_pkg;

  localparam int unsigned POS_WIDTH = 16;
  localparam int unsigned KIND_WIDTH = 5;
  localparam int unsigned MODE_WIDTH = 3;
  localparam int unsigned PEND_WIDTH = 3;
  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned COUNT_WIDTH = 2;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [KIND_WIDTH-1:0] kind_t;
  typedef logic [MODE_WIDTH-1:0] mode_t;
  typedef logic [PEND_WIDTH-1:0] pend_t;

  localparam pos_t POS_MAX = {POS_WIDTH{1'b1}};
  localparam pos_t POS_ONE = pos_t'(1);

  // scan modes
  localparam mode_t MODE_NORMAL = 3'd0;
  localparam mode_t MODE_LINE = 3'd1;
  localparam mode_t MODE_BLOCK = 3'd2;
  localparam mode_t MODE_STAR = 3'd3;

  // pending operator codes
  localparam pend_t PEND_NONE = 3'd0;
  localparam pend_t PEND_EQ = 3'd1;
  localparam pend_t PEND_BANG = 3'd2;
  localparam pend_t PEND_LT = 3'd3;
  localparam pend_t PEND_GT = 3'd4;
  localparam pend_t PEND_SLASH = 3'd5;

  // token kinds
  localparam kind_t KIND_EOF = 5'd0;
  localparam kind_t KIND_ERROR = 5'd1;
  localparam kind_t KIND_LPAREN = 5'd2;
  localparam kind_t KIND_RPAREN = 5'd3;
  localparam kind_t KIND_LBRACE = 5'd4;
  localparam kind_t KIND_RBRACE = 5'd5;
  localparam kind_t KIND_LBRACK = 5'd6;
  localparam kind_t KIND_RBRACK = 5'd7;
  localparam kind_t KIND_SEMI = 5'd8;
  localparam kind_t KIND_COMMA = 5'd9;
  localparam kind_t KIND_COLON = 5'd10;
  localparam kind_t KIND_DOT = 5'd11;
  localparam kind_t KIND_PLUS = 5'd12;
  localparam kind_t KIND_MINUS = 5'd13;
  localparam kind_t KIND_STAR = 5'd14;
  localparam kind_t KIND_SLASH = 5'd15;
  localparam kind_t KIND_PERCENT = 5'd16;
  localparam kind_t KIND_ASSIGN = 5'd17;

  // characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_EQ = 8'h3D;

  typedef struct packed {
    kind_t kind;
    pos_t line;
    pos_t column;
    logic last;
  } token_t;

  function automatic pos_t sat_inc(input pos_t v);
    sat_inc = (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  // kind of a single-character token, KIND_EOF when none
  function automatic kind_t single_kind(input logic [7:0] b);
    case (b)
      8'h28:   single_kind = KIND_LPAREN;
      8'h29:   single_kind = KIND_RPAREN;
      8'h7B:   single_kind = KIND_LBRACE;
      8'h7D:   single_kind = KIND_RBRACE;
      8'h5B:   single_kind = KIND_LBRACK;
      8'h5D:   single_kind = KIND_RBRACK;
      8'h3B:   single_kind = KIND_SEMI;
      8'h2C:   single_kind = KIND_COMMA;
      8'h3A:   single_kind = KIND_COLON;
      8'h2E:   single_kind = KIND_DOT;
      8'h2B:   single_kind = KIND_PLUS;
      8'h2D:   single_kind = KIND_MINUS;
      CH_STAR: single_kind = KIND_STAR;
      8'h25:   single_kind = KIND_PERCENT;
      default: single_kind = KIND_EOF;
    endcase
  endfunction

  // first character of a possible two-character token
  function automatic pend_t op_code(input logic [7:0] b);
    case (b)
      CH_EQ:    op_code = PEND_EQ;
      8'h21:    op_code = PEND_BANG;
      8'h3C:    op_code = PEND_LT;
      8'h3E:    op_code = PEND_GT;
      CH_SLASH: op_code = PEND_SLASH;
      default:  op_code = PEND_NONE;
    endcase
  endfunction

endpackage

// File: rtl/punctuation_tokenizer.sv
// ----------------------------------------------------------------------------
// punctuation_tokenizer
// operator and punctuation scanner, one source byte per word
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle and updates its scan state in the
// same cycle; the tokens that a byte causes go into a three-word output queue.
// A byte gives zero, one or two tokens, and the output port moves one token per
// cycle while out_ready_i is high, so input is taken whenever at most one token
// is waiting. Bytes that give at most one token each flow at one byte per cycle
// while the output drains; a byte that gives two tokens (a pending operator or
// slash flushed ahead of its own token) holds off input until the queue is back
// to one token. Byte 0 ends the source: it flushes, gives EOF and returns the
// line and column counters, mode and pending operator to their reset values.

module punctuation_tokenizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         char_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ptok_pkg::KIND_WIDTH-1:0]    token_kind_o,
  output logic [ptok_pkg::POS_WIDTH-1:0]     token_line_o,
  output logic [ptok_pkg::POS_WIDTH-1:0]     token_column_o,
  output logic                               last_of_run_o
);

  ptok_pkg::mode_t mode_q, mode_d;
  ptok_pkg::pend_t pend_q, pend_d;
  ptok_pkg::pos_t line_q, line_d;
  ptok_pkg::pos_t col_q, col_d;
  ptok_pkg::pos_t pcol_q, pcol_d;

  ptok_pkg::token_t queue_q [ptok_pkg::QUEUE_DEPTH];
  ptok_pkg::token_t queue_d [ptok_pkg::QUEUE_DEPTH];
  logic [ptok_pkg::COUNT_WIDTH-1:0] count_q, count_d;

  logic accept;
  logic pop;
  logic [1:0] push_n;
  ptok_pkg::token_t tok0, tok1;

  assign accept = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign in_ready_o = (count_q <= ptok_pkg::COUNT_WIDTH'(1));
  assign out_valid_o = (count_q != '0);

  assign token_kind_o = queue_q[0].kind;
  assign token_line_o = queue_q[0].line;
  assign token_column_o = queue_q[0].column;
  assign last_of_run_o = queue_q[0].last;

  // scan step
  always_comb begin
    logic [7:0] b;
    logic pend_emit;
    ptok_pkg::kind_t pend_kind;
    logic do_norm;
    logic nb_emit;
    ptok_pkg::kind_t nb_kind;
    ptok_pkg::pos_t nb_col;
    ptok_pkg::kind_t sk;
    ptok_pkg::pend_t oc;

    b = char_in_i;
    mode_d = mode_q;
    pend_d = pend_q;
    line_d = line_q;
    col_d = col_q;
    pcol_d = pcol_q;
    pend_emit = 1'b0;
    pend_kind = ptok_pkg::KIND_EOF;
    do_norm = 1'b0;
    nb_emit = 1'b0;
    nb_kind = ptok_pkg::KIND_EOF;
    nb_col = col_q;
    sk = ptok_pkg::single_kind(b);
    oc = ptok_pkg::op_code(b);

    case (mode_q)
      ptok_pkg::MODE_LINE: begin
        if (b == ptok_pkg::CH_NUL) begin
          do_norm = 1'b1;
        end else if (b == ptok_pkg::CH_NL) begin
          mode_d = ptok_pkg::MODE_NORMAL;
          line_d = ptok_pkg::sat_inc(line_q);
          col_d = ptok_pkg::POS_ONE;
        end else begin
          col_d = ptok_pkg::sat_inc(col_q);
        end
      end
      ptok_pkg::MODE_BLOCK, ptok_pkg::MODE_STAR: begin
        if (b == ptok_pkg::CH_NUL) begin
          do_norm = 1'b1;
        end else if (b == ptok_pkg::CH_NL) begin
          mode_d = ptok_pkg::MODE_BLOCK;
          line_d = ptok_pkg::sat_inc(line_q);
          col_d = ptok_pkg::POS_ONE;
        end else if (mode_q == ptok_pkg::MODE_STAR && b == ptok_pkg::CH_SLASH) begin
          mode_d = ptok_pkg::MODE_NORMAL;
          col_d = ptok_pkg::sat_inc(col_q);
        end else begin
          mode_d = (b == ptok_pkg::CH_STAR) ? ptok_pkg::MODE_STAR : ptok_pkg::MODE_BLOCK;
          col_d = ptok_pkg::sat_inc(col_q);
        end
      end
      default: begin
        mode_d = ptok_pkg::MODE_NORMAL;
        pend_d = ptok_pkg::PEND_NONE;
        if (pend_q inside {[ptok_pkg::PEND_EQ:ptok_pkg::PEND_GT]}) begin
          // base kind is 15 + 2 * code, the "=" form one above
          pend_emit = 1'b1;
          pend_kind = ptok_pkg::kind_t'(ptok_pkg::KIND_SLASH + {pend_q, 1'b0});
          if (b == ptok_pkg::CH_EQ) begin
            pend_kind = pend_kind + ptok_pkg::kind_t'(1);
            col_d = ptok_pkg::sat_inc(col_q);
          end else begin
            do_norm = 1'b1;
          end
        end else if (pend_q == ptok_pkg::PEND_SLASH) begin
          if (b == ptok_pkg::CH_SLASH) begin
            mode_d = ptok_pkg::MODE_LINE;
            col_d = ptok_pkg::sat_inc(col_q);
          end else if (b == ptok_pkg::CH_STAR) begin
            mode_d = ptok_pkg::MODE_BLOCK;
            col_d = ptok_pkg::sat_inc(col_q);
          end else begin
            pend_emit = 1'b1;
            pend_kind = ptok_pkg::KIND_SLASH;
            do_norm = 1'b1;
          end
        end else begin
          do_norm = 1'b1;
        end
      end
    endcase

    if (do_norm) begin
      if (b == ptok_pkg::CH_NUL) begin
        nb_emit = 1'b1;
        nb_kind = ptok_pkg::KIND_EOF;
        mode_d = ptok_pkg::MODE_NORMAL;
        pend_d = ptok_pkg::PEND_NONE;
        line_d = ptok_pkg::POS_ONE;
        col_d = ptok_pkg::POS_ONE;
        pcol_d = '0;
      end else if (b inside {ptok_pkg::CH_SPACE, ptok_pkg::CH_TAB, ptok_pkg::CH_CR}) begin
        col_d = ptok_pkg::sat_inc(col_q);
      end else if (b == ptok_pkg::CH_NL) begin
        line_d = ptok_pkg::sat_inc(line_q);
        col_d = ptok_pkg::POS_ONE;
      end else if (sk != ptok_pkg::KIND_EOF) begin
        nb_emit = 1'b1;
        nb_kind = sk;
        col_d = ptok_pkg::sat_inc(col_q);
      end else if (oc != ptok_pkg::PEND_NONE) begin
        pend_d = oc;
        pcol_d = col_q;
        col_d = ptok_pkg::sat_inc(col_q);
      end else begin
        nb_emit = 1'b1;
        nb_kind = ptok_pkg::KIND_ERROR;
        nb_col = ptok_pkg::sat_inc(col_q);
        col_d = nb_col;
      end
    end

    tok0 = '{kind: pend_kind, line: line_q, column: pcol_q, last: !nb_emit};
    tok1 = '{kind: nb_kind, line: line_q, column: nb_col, last: 1'b1};
    if (pend_emit) begin
      push_n = nb_emit ? 2'd2 : 2'd1;
    end else begin
      tok0 = tok1;
      push_n = nb_emit ? 2'd1 : 2'd0;
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  // output queue, head at entry 0
  always_comb begin
    logic [ptok_pkg::COUNT_WIDTH-1:0] base;

    base = count_q - ptok_pkg::COUNT_WIDTH'(pop);
    for (int i = 0; i < ptok_pkg::QUEUE_DEPTH; i++) begin
      if (pop && i < ptok_pkg::QUEUE_DEPTH - 1) begin
        queue_d[i] = queue_q[i+1];
      end else begin
        queue_d[i] = queue_q[i];
      end
      if (push_n != 2'd0 && ptok_pkg::COUNT_WIDTH'(i) == base) begin
        queue_d[i] = tok0;
      end
      if (push_n == 2'd2 && ptok_pkg::COUNT_WIDTH'(i) == base + ptok_pkg::COUNT_WIDTH'(1)) begin
        queue_d[i] = tok1;
      end
    end
    count_d = base + ptok_pkg::COUNT_WIDTH'(push_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ptok_pkg::MODE_NORMAL;
      pend_q <= ptok_pkg::PEND_NONE;
      line_q <= ptok_pkg::POS_ONE;
      col_q <= ptok_pkg::POS_ONE;
      pcol_q <= '0;
      count_q <= '0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        line_q <= line_d;
        col_q <= col_d;
        pcol_q <= pcol_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ptok_pkg::QUEUE_DEPTH; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ptok_pkg::COUNT_WIDTH'(ptok_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && char_in_i == ptok_pkg::CH_NUL |=>
      line_q == ptok_pkg::POS_ONE && col_q == ptok_pkg::POS_ONE &&
      mode_q == ptok_pkg::MODE_NORMAL && pend_q == ptok_pkg::PEND_NONE)
    else $error("end of source did not reset scan state");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_line_o != '0)
    else $error("token line is zero");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == ptok_pkg::KIND_EOF |-> last_of_run_o)
    else $error("eof token not marked last");
`endif

endmodule
